>>> rtl/core/byte_vm_instruction_execute_core_assert.svh
// Assertion macros for the checker of the instruction execute core.
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock and masked during reset.
`define BVM_ASSERT_HOLD(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("instruction execute core check failed");

// Next-cycle implication, sampled on clock and masked during reset.
`define BVM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("instruction execute core check failed");

`endif

>>> rtl/core/bvm_pkg.sv
// Shared types, constants and helper functions of the instruction execute core.
`timescale 1ns / 1ps
package bvm_pkg;

   // Storage sizes. The data memory depth must be a power of two.
   localparam int MEM_BYTES   = 4096;
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int STACK_DEPTH = 16;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int PC_W        = 12;
   localparam int SUM_W       = ((MEM_AW > PC_W) ? MEM_AW : PC_W) + 1;

   localparam logic [PC_W-1:0] START_ADDRESS_RESET = 12'd512;
   localparam logic [PC_W-1:0] PC_STEP             = 12'd2;
   localparam logic [3:0]      FLAG_REG            = 4'hF;
   localparam logic [3:0]      BCD_LAST            = 4'd2;
   localparam logic [15:0]     INSTR_RET           = 16'h00EE;

   // Opcode groups, taken from the top nibble.
   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SE   = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LD   = 4'h6;
   localparam logic [3:0] OP_ADD  = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV  = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_MISC = 4'hF;

   // ALU group codes, taken from the low nibble.
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // Misc group codes, taken from the low byte.
   localparam logic [7:0] MISC_GET_DT = 8'h07;
   localparam logic [7:0] MISC_SET_DT = 8'h15;
   localparam logic [7:0] MISC_SET_ST = 8'h18;
   localparam logic [7:0] MISC_ADD_I  = 8'h1E;
   localparam logic [7:0] MISC_BCD    = 8'h33;
   localparam logic [7:0] MISC_STORE  = 8'h55;
   localparam logic [7:0] MISC_LOAD   = 8'h65;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_UNIMPL = 2'd1,
      STATUS_STACK  = 2'd2
   } status_type;

   // Which tail an instruction needs after its execute cycle.
   typedef enum logic [2:0] {
      SEQ_SIMPLE = 3'd0,
      SEQ_FLAG   = 3'd1,
      SEQ_BCD    = 3'd2,
      SEQ_STORE  = 3'd3,
      SEQ_LOAD   = 3'd4
   } seq_type;

   typedef struct packed {
      logic [15:0] instruction_word;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0] next_pc;
      logic [PC_W-1:0] index_value;
      logic [3:0]      dest_reg;
      logic [7:0]      dest_value;
      logic [7:0]      flag_value;
      logic [7:0]      delay_value;
      logic [7:0]      sound_value;
      status_type      status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              pc_init;
      logic              clr_wr;
      logic [MEM_AW-1:0] clr_addr;
      logic              fetch;
      logic              exec;
      logic              flag_wr;
      logic              bcd_wr;
      logic              st_rd;
      logic              st_wr;
      logic              ld_rd;
      logic              ld_wr;
      logic              load_rsp;
      logic [3:0]        step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      seq_type    seq;
      logic [3:0] x;
   } stat_type;

   // One decimal digit of a byte: select 0 gives hundreds, 1 tens, 2 ones.
   function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
      logic [7:0] hun;
      logic [7:0] rem;
      logic [7:0] ten;
      logic [7:0] one;
      hun = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
      rem = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
      ten = 8'd0;
      for (int i = 1; i <= 9; i++) begin
         if (rem >= 8'(i * 10)) begin
            ten = 8'(i);
         end
      end
      one = rem - 8'(ten * 8'd10);
      case (sel)
         2'd0:    bcd_digit = hun;
         2'd1:    bcd_digit = ten;
         default: bcd_digit = one;
      endcase
   endfunction

endpackage

>>> rtl/core/bvm_ctrl.sv
// Controller state machine that sequences the memory clear and each instruction.
`timescale 1ns / 1ps
module bvm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bvm_pkg::stat_type stat,
   output bvm_pkg::cmd_type  cmd
);

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_FETCH = 12'b000000000100,
      S_EXEC  = 12'b000000001000,
      S_FLAG  = 12'b000000010000,
      S_BCD   = 12'b000000100000,
      S_ST_RD = 12'b000001000000,
      S_ST_WR = 12'b000010000000,
      S_LD_RD = 12'b000100000000,
      S_LD_WR = 12'b001000000000,
      S_RBACK = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [bvm_pkg::MEM_AW-1:0] clr_ff, clr_in;
   logic [3:0]                step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Next state, counters and commands.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.clr_addr = clr_ff;
      cmd.step     = step_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.pc_init = (clr_ff == '0);
            if (clr_ff == bvm_pkg::MEM_AW'(bvm_pkg::MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            step_in  = '0;
            case (stat.seq)
               bvm_pkg::SEQ_FLAG:  state_in = S_FLAG;
               bvm_pkg::SEQ_BCD:   state_in = S_BCD;
               bvm_pkg::SEQ_STORE: state_in = S_ST_RD;
               bvm_pkg::SEQ_LOAD:  state_in = S_LD_RD;
               default:            state_in = S_RBACK;
            endcase
         end
         S_FLAG: begin
            cmd.flag_wr = 1'b1;
            state_in    = S_RBACK;
         end
         S_BCD: begin
            cmd.bcd_wr = 1'b1;
            if (step_ff == bvm_pkg::BCD_LAST) begin
               state_in = S_RBACK;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ST_RD: begin
            cmd.st_rd = 1'b1;
            state_in  = S_ST_WR;
         end
         S_ST_WR: begin
            cmd.st_wr = 1'b1;
            if (step_ff == stat.x) begin
               state_in = S_RBACK;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_ST_RD;
            end
         end
         S_LD_RD: begin
            cmd.ld_rd = 1'b1;
            state_in  = S_LD_WR;
         end
         S_LD_WR: begin
            cmd.ld_wr = 1'b1;
            if (step_ff == stat.x) begin
               state_in = S_RBACK;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_LD_RD;
            end
         end
         S_RBACK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The response register fills on load and drains when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/bvm_datapath.sv
// Datapath: register file, data memory, call stack, machine registers and execute logic.
`timescale 1ns / 1ps
module bvm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bvm_pkg::req_type         req_payload,
   input  logic                    csr_valid,
   input  logic [bvm_pkg::PC_W-1:0] csr_data,
   input  bvm_pkg::cmd_type         cmd,
   output bvm_pkg::stat_type        stat,
   output bvm_pkg::rsp_type         rsp_payload
);

   localparam int PW = bvm_pkg::PC_W;
   localparam int AW = bvm_pkg::MEM_AW;

   // Storage.
   logic [7:0]    rf_mem [16];
   logic [15:0]   rf_valid_ff;
   logic [7:0]    data_mem [bvm_pkg::MEM_BYTES];
   logic [PW-1:0] stack_ff [bvm_pkg::STACK_DEPTH];

   // Machine registers.
   logic [PW-1:0]            start_address_ff;
   logic [PW-1:0]            pc_ff, index_ff;
   logic [bvm_pkg::SP_W-1:0] sp_ff;
   logic [7:0]               delay_ff, sound_ff;
   bvm_pkg::req_type         req_ff;
   bvm_pkg::status_type      status_ff;
   logic [7:0]               flag_ff;
   logic [7:0]               rd_a_ff, rd_b_ff, mem_rd_ff;
   bvm_pkg::rsp_type         rsp_ff;

   // Instruction fields.
   logic [3:0]  op, x, y, n;
   logic [7:0]  kk;
   logic [PW-1:0] nnn;
   assign op  = req_ff.instruction_word[15:12];
   assign x   = req_ff.instruction_word[11:8];
   assign y   = req_ff.instruction_word[7:4];
   assign n   = req_ff.instruction_word[3:0];
   assign kk  = req_ff.instruction_word[7:0];
   assign nnn = req_ff.instruction_word[11:0];

   // Tail sequence decode.
   always_comb begin
      stat.x   = x;
      stat.seq = bvm_pkg::SEQ_SIMPLE;
      if (op == bvm_pkg::OP_MISC) begin
         case (kk)
            bvm_pkg::MISC_BCD:   stat.seq = bvm_pkg::SEQ_BCD;
            bvm_pkg::MISC_STORE: stat.seq = bvm_pkg::SEQ_STORE;
            bvm_pkg::MISC_LOAD:  stat.seq = bvm_pkg::SEQ_LOAD;
            default:             stat.seq = bvm_pkg::SEQ_SIMPLE;
         endcase
      end else if (op == bvm_pkg::OP_ALU) begin
         case (n)
            bvm_pkg::ALU_ADD, bvm_pkg::ALU_SUB, bvm_pkg::ALU_SHR,
            bvm_pkg::ALU_SUBN, bvm_pkg::ALU_SHL: stat.seq = bvm_pkg::SEQ_FLAG;
            default:                             stat.seq = bvm_pkg::SEQ_SIMPLE;
         endcase
      end
   end

   // Execute cycle: next machine state from Vx (port A) and Vy or V0 (port B).
   localparam int STACK_AW_W = bvm_pkg::STACK_AW;
   logic [PW-1:0]            pc_inc, pc_next, idx_next;
   logic [bvm_pkg::SP_W-1:0] sp_next;
   logic                     push;
   logic [7:0]               dt_next, st_next, wr_val, flag_next;
   logic                     wr_x;
   bvm_pkg::status_type      status_next;
   logic [8:0]               sum9;
   logic [STACK_AW_W-1:0]    pop_idx;

   assign pc_inc  = pc_ff + bvm_pkg::PC_STEP;
   assign sum9    = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   assign pop_idx = STACK_AW_W'(sp_ff - 1'b1);

   always_comb begin
      pc_next     = pc_inc;
      idx_next    = index_ff;
      sp_next     = sp_ff;
      push        = 1'b0;
      dt_next     = delay_ff;
      st_next     = sound_ff;
      wr_x        = 1'b0;
      wr_val      = rd_a_ff;
      flag_next   = flag_ff;
      status_next = bvm_pkg::STATUS_OK;
      unique case (op)
         bvm_pkg::OP_SYS: begin
            if (req_ff.instruction_word == bvm_pkg::INSTR_RET) begin
               if (sp_ff == '0) begin
                  status_next = bvm_pkg::STATUS_STACK;
               end else begin
                  sp_next = sp_ff - 1'b1;
                  pc_next = stack_ff[pop_idx];
               end
            end else begin
               status_next = bvm_pkg::STATUS_UNIMPL;
            end
         end
         bvm_pkg::OP_JP: pc_next = nnn;
         bvm_pkg::OP_CALL: begin
            if (sp_ff >= bvm_pkg::SP_W'(bvm_pkg::STACK_DEPTH)) begin
               status_next = bvm_pkg::STATUS_STACK;
            end else begin
               push    = 1'b1;
               sp_next = sp_ff + 1'b1;
               pc_next = nnn;
            end
         end
         bvm_pkg::OP_SE: begin
            if (rd_a_ff == kk) pc_next = pc_inc + bvm_pkg::PC_STEP;
         end
         bvm_pkg::OP_SNE: begin
            if (rd_a_ff != kk) pc_next = pc_inc + bvm_pkg::PC_STEP;
         end
         bvm_pkg::OP_SER: begin
            if (n != 4'h0) begin
               status_next = bvm_pkg::STATUS_UNIMPL;
            end else if (rd_a_ff == rd_b_ff) begin
               pc_next = pc_inc + bvm_pkg::PC_STEP;
            end
         end
         bvm_pkg::OP_LD: begin
            wr_x   = 1'b1;
            wr_val = kk;
         end
         bvm_pkg::OP_ADD: begin
            wr_x   = 1'b1;
            wr_val = rd_a_ff + kk;
         end
         bvm_pkg::OP_ALU: begin
            wr_x = 1'b1;
            case (n)
               bvm_pkg::ALU_MOV: wr_val = rd_b_ff;
               bvm_pkg::ALU_OR:  wr_val = rd_a_ff | rd_b_ff;
               bvm_pkg::ALU_AND: wr_val = rd_a_ff & rd_b_ff;
               bvm_pkg::ALU_XOR: wr_val = rd_a_ff ^ rd_b_ff;
               bvm_pkg::ALU_ADD: begin
                  wr_val    = sum9[7:0];
                  flag_next = {7'd0, sum9[8]};
               end
               bvm_pkg::ALU_SUB: begin
                  wr_val    = rd_a_ff - rd_b_ff;
                  flag_next = {7'd0, (rd_a_ff >= rd_b_ff)};
               end
               bvm_pkg::ALU_SHR: begin
                  wr_val    = {1'b0, rd_a_ff[7:1]};
                  flag_next = {7'd0, rd_a_ff[0]};
               end
               bvm_pkg::ALU_SUBN: begin
                  wr_val    = rd_b_ff - rd_a_ff;
                  flag_next = {7'd0, (rd_b_ff >= rd_a_ff)};
               end
               bvm_pkg::ALU_SHL: begin
                  wr_val    = {rd_a_ff[6:0], 1'b0};
                  flag_next = {7'd0, rd_a_ff[7]};
               end
               default: begin
                  wr_x        = 1'b0;
                  status_next = bvm_pkg::STATUS_UNIMPL;
               end
            endcase
         end
         bvm_pkg::OP_SNER: begin
            if (n != 4'h0) begin
               status_next = bvm_pkg::STATUS_UNIMPL;
            end else if (rd_a_ff != rd_b_ff) begin
               pc_next = pc_inc + bvm_pkg::PC_STEP;
            end
         end
         bvm_pkg::OP_LDI: idx_next = nnn;
         bvm_pkg::OP_JPV: pc_next = nnn + {{(PW-8){1'b0}}, rd_b_ff};
         bvm_pkg::OP_RND: begin
            wr_x   = 1'b1;
            wr_val = req_ff.random_byte & kk;
         end
         bvm_pkg::OP_MISC: begin
            case (kk)
               bvm_pkg::MISC_GET_DT: begin
                  wr_x   = 1'b1;
                  wr_val = delay_ff;
               end
               bvm_pkg::MISC_SET_DT: dt_next = rd_a_ff;
               bvm_pkg::MISC_SET_ST: st_next = rd_a_ff;
               bvm_pkg::MISC_ADD_I:  idx_next = index_ff + {{(PW-8){1'b0}}, rd_a_ff};
               bvm_pkg::MISC_BCD, bvm_pkg::MISC_STORE, bvm_pkg::MISC_LOAD: begin
                  status_next = bvm_pkg::STATUS_OK;
               end
               default: status_next = bvm_pkg::STATUS_UNIMPL;
            endcase
         end
         default: status_next = bvm_pkg::STATUS_UNIMPL;
      endcase
   end

   // Register file ports: A reads Vx or the loop register, B reads Vy, V0 or the flag.
   logic [3:0] ra, rb, waddr;
   logic       we;
   logic [7:0] wdata;

   assign ra = cmd.st_rd ? cmd.step : x;
   assign rb = cmd.fetch ? ((op == bvm_pkg::OP_JPV) ? 4'h0 : y) : bvm_pkg::FLAG_REG;

   always_comb begin
      we    = 1'b0;
      waddr = x;
      wdata = wr_val;
      if (cmd.exec && wr_x) begin
         we = 1'b1;
      end else if (cmd.flag_wr) begin
         we    = 1'b1;
         waddr = bvm_pkg::FLAG_REG;
         wdata = flag_ff;
      end else if (cmd.ld_wr) begin
         we    = 1'b1;
         waddr = cmd.step;
         wdata = mem_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         rf_mem[waddr] <= wdata;
      end
      rd_a_ff <= (rf_valid_ff[ra] && !reset) ? rf_mem[ra] : 8'd0;
      rd_b_ff <= (rf_valid_ff[rb] && !reset) ? rf_mem[rb] : 8'd0;
   end

   // Register valid bits: a register never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (we) begin
         rf_valid_ff[waddr] <= 1'b1;
      end
   end

   // Data memory: address wraps at the memory size.
   logic [AW-1:0] mem_addr;
   assign mem_addr = AW'(bvm_pkg::SUM_W'(index_ff) + bvm_pkg::SUM_W'(cmd.step));

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         data_mem[cmd.clr_addr] <= 8'd0;
      end else if (cmd.bcd_wr) begin
         data_mem[mem_addr] <= bvm_pkg::bcd_digit(rd_a_ff, cmd.step[1:0]);
      end else if (cmd.st_wr) begin
         data_mem[mem_addr] <= rd_a_ff;
      end
      if (cmd.ld_rd) begin
         mem_rd_ff <= data_mem[mem_addr];
      end
   end

   // Call stack entries are only read after being pushed.
   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         stack_ff[sp_ff[STACK_AW_W-1:0]] <= pc_inc;
      end
   end

   // Machine control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= bvm_pkg::START_ADDRESS_RESET;
         pc_ff            <= bvm_pkg::START_ADDRESS_RESET;
         index_ff         <= '0;
         sp_ff            <= '0;
         delay_ff         <= 8'd0;
         sound_ff         <= 8'd0;
      end else begin
         if (csr_valid) begin
            start_address_ff <= csr_data;
         end
         if (cmd.pc_init) begin
            pc_ff <= start_address_ff;
         end else if (cmd.exec) begin
            pc_ff    <= pc_next;
            index_ff <= idx_next;
            sp_ff    <= sp_next;
            delay_ff <= dt_next;
            sound_ff <= st_next;
         end
      end
   end

   // Request capture, execute results and the response register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.exec) begin
         status_ff <= status_next;
         flag_ff   <= flag_next;
      end
      if (cmd.load_rsp) begin
         rsp_ff.next_pc     <= pc_ff;
         rsp_ff.index_value <= index_ff;
         rsp_ff.dest_reg    <= x;
         rsp_ff.dest_value  <= rd_a_ff;
         rsp_ff.flag_value  <= rd_b_ff;
         rsp_ff.delay_value <= delay_ff;
         rsp_ff.sound_value <= sound_ff;
         rsp_ff.status      <= status_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/byte_vm_instruction_execute_core.sv
// Top level of the instruction execute core: controller plus datapath.
// Sequence: capture on accept, fetch, execute, an optional tail (flag write, BCD store,
// or block store or load of x+1 registers), readback, then done, which loads the response
// register once any previous response is taken. Throughput: one request at a time, taken
// the cycle after the previous one loads the response register.
// Reset: synchronous; then a memory clear pass over all 4096 bytes with no request accepted.
`timescale 1ns / 1ps
module byte_vm_instruction_execute_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bvm_pkg::req_type         req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bvm_pkg::rsp_type         rsp_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [bvm_pkg::PC_W-1:0] csr_data
);

   bvm_pkg::cmd_type  cmd;
   bvm_pkg::stat_type stat;

   // The start address register takes a write in any cycle outside reset.
   assign csr_ready = 1'b1;

   bvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bvm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/bvm_checker.sv
// Port-level checker of the instruction execute core and its bind.
`timescale 1ns / 1ps
`include "byte_vm_instruction_execute_core_assert.svh"
module bvm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input bvm_pkg::rsp_type         rsp_payload,
   input logic                    csr_valid,
   input logic                    csr_ready
);

   // A stalled response holds its payload.
   `BVM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Only one request is in flight: ready drops right after an accept.
   `BVM_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready)

   // A response never carries the unused status code.
   `BVM_ASSERT_HOLD(a_status_code, rsp_valid,
      rsp_payload.status == bvm_pkg::STATUS_OK || rsp_payload.status == bvm_pkg::STATUS_UNIMPL ||
      rsp_payload.status == bvm_pkg::STATUS_STACK)

   // The start address register never stalls a write.
   `BVM_ASSERT_HOLD(a_csr_ready, csr_valid, csr_ready)

endmodule

bind byte_vm_instruction_execute_core bvm_checker u_checker (.*);
